// ===== rtl/psls_pkg.sv =====
package psls_pkg;

   // Field widths fixed by the item formats
   localparam int DATA_W     = 32;
   localparam int TOTAL_W    = 48;
   localparam int CMD_W      = 2;
   localparam int SRC_W      = 4;
   localparam int STEP_CNT_W = 6;

   // Command codes; any other code reads the entry
   localparam logic [CMD_W-1:0] CMD_PRODUCED = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CONSUMED = 2'd1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SRC_W-1:0]  source;
      logic [DATA_W-1:0] delay;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] made_count;
      logic [DATA_W-1:0] eaten_count;
      logic [DATA_W-1:0] low_delay;
      logic [DATA_W-1:0] peak_delay;
      logic [DATA_W-1:0] mean_delay;
      logic              mismatch;
   } rsp_payload_type;

   // One row of the statistics table
   typedef struct packed {
      logic [DATA_W-1:0]  made;
      logic [DATA_W-1:0]  eaten;
      logic [DATA_W-1:0]  min_val;
      logic [DATA_W-1:0]  max_val;
      logic [TOTAL_W-1:0] total;
   } entry_type;

endpackage

// ===== rtl/psls_req_if.sv =====
interface psls_req_if;
   import psls_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/psls_rsp_if.sv =====
interface psls_rsp_if;
   import psls_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/per_source_latency_stats_table_core.sv =====
// Per-source latency statistics table.
// req_ch carries one request: a command (produced, consumed with a delay
// sample, or read), a source index and the delay. rsp_ch returns one result
// per request: made and eaten counts, min and max delay, the average delay
// and a mismatch flag, all taken after the request's update.
// One request is worked on at a time; req_ch.ready is high only while idle.
// A request for a source below NUM_SOURCES reads its table row, passes the
// counts, the total and the min/max compares through shift registers one bit
// a cycle, then, if the eaten count is nonzero, a radix-2 divider forms
// total/eaten one quotient bit a cycle (else the average is zero). A source
// beyond NUM_SOURCES gets an all-zero result, table untouched. The cycle after
// the result is loaded, the core is idle and can take the next request.
// A result that the receiver stalls stays in the output register while the
// next request is accepted and worked on; that one then waits for the slot.
// Reset clears every row at once (per-row valid bits) and the handshakes;
// requests are taken from the first cycle after reset.
module per_source_latency_stats_table_core #(
   parameter int NUM_SOURCES = 16
) (
   input  logic       clock,
   input  logic       reset,
   psls_req_if.sink   req_ch,
   psls_rsp_if.source rsp_ch
);
   import psls_pkg::*;

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int CMP_W = ((IDX_W > SRC_W) ? IDX_W : SRC_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_SERIAL,
      S_FIX,
      S_WRITE,
      S_DIV,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [CMD_W-1:0]       cmd_ff;
   entry_type              rd_entry_ff;
   logic                   rd_valid_ff;
   logic                   valid_ff [NUM_SOURCES];
   entry_type              mem [NUM_SOURCES];

   logic [DATA_W-1:0]      made_sr_ff;
   logic [DATA_W-1:0]      eaten_sr_ff;
   logic [DATA_W-1:0]      min_sr_ff;
   logic [DATA_W-1:0]      max_sr_ff;
   logic [DATA_W-1:0]      d_sr_ff;
   logic [TOTAL_W-1:0]     total_sr_ff;
   logic                   made_c_ff;
   logic                   eaten_c_ff;
   logic                   total_c_ff;
   logic                   eaten_nz_ff;
   logic                   lt_ff;
   logic                   gt_ff;
   logic [STEP_CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0]      avg_ff;
   logic                   mismatch_ff;
   logic                   div_start_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff;

   logic [CMP_W-1:0]       src_ext;
   logic                   in_range;
   logic                   produced;
   logic                   consumed;
   logic                   low_bits;
   logic                   made_bit_in;
   logic                   eaten_bit_in;
   logic                   add_bit;
   logic                   total_bit_in;
   logic                   total_c_in;
   entry_type              load_entry;
   entry_type              wr_entry;
   logic                   first_sample;
   logic                   div_done;
   logic [DATA_W-1:0]      div_quot;
   logic                   rsp_load;

   // Request decode
   assign src_ext  = CMP_W'(req_ch.payload.source);
   assign in_range = src_ext < CMP_W'(NUM_SOURCES);
   assign produced = (cmd_ff == CMD_PRODUCED);
   assign consumed = (cmd_ff == CMD_CONSUMED);

   // Row as read; a row never written since reset reads as zero
   assign load_entry = rd_valid_ff ? rd_entry_ff : '0;

   // Bit-serial update, LSB first; 32-bit fields move only in the low 32 steps
   always_comb begin
      low_bits     = ~cnt_ff[STEP_CNT_W-1];
      made_bit_in  = made_sr_ff[0] ^ made_c_ff;
      eaten_bit_in = eaten_sr_ff[0] ^ eaten_c_ff;
      add_bit      = low_bits & consumed & d_sr_ff[0];
      total_bit_in = total_sr_ff[0] ^ add_bit ^ total_c_ff;
      total_c_in   = (total_sr_ff[0] & add_bit) | (total_sr_ff[0] & total_c_ff)
                   | (add_bit & total_c_ff);
      first_sample = ~eaten_nz_ff;
   end

   assign wr_entry = '{made: made_sr_ff, eaten: eaten_sr_ff, min_val: min_sr_ff,
                       max_val: max_sr_ff, total: total_sr_ff};

   // Output slot is loaded once the result is ready and the slot is free
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rd_entry_ff <= mem[idx_ff];
      end
      if (state_ff == S_WRITE) begin
         mem[idx_ff] <= wr_entry;
      end
   end

   // Row valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (state_ff == S_WRITE) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Average divider
   psls_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (total_sr_ff),
      .divisor  (eaten_sr_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= (state_ff == S_WRITE) && (eaten_sr_ff != '0);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  cmd_ff  <= req_ch.payload.cmd;
                  d_sr_ff <= req_ch.payload.delay;
                  idx_ff  <= src_ext[IDX_W-1:0];
                  if (in_range) begin
                     state_ff <= S_READ;
                  end else begin
                     // unknown source: all-zero result, table untouched
                     made_sr_ff  <= '0;
                     eaten_sr_ff <= '0;
                     min_sr_ff   <= '0;
                     max_sr_ff   <= '0;
                     avg_ff      <= '0;
                     mismatch_ff <= 1'b0;
                     state_ff    <= S_DONE;
                  end
               end
            end
            S_READ: begin
               rd_valid_ff <= valid_ff[idx_ff];
               state_ff    <= S_LOAD;
            end
            S_LOAD: begin
               made_sr_ff  <= load_entry.made;
               eaten_sr_ff <= load_entry.eaten;
               min_sr_ff   <= load_entry.min_val;
               max_sr_ff   <= load_entry.max_val;
               total_sr_ff <= load_entry.total;
               made_c_ff   <= produced;
               eaten_c_ff  <= consumed;
               total_c_ff  <= 1'b0;
               eaten_nz_ff <= 1'b0;
               lt_ff       <= 1'b0;
               gt_ff       <= 1'b0;
               cnt_ff      <= '0;
               state_ff    <= S_SERIAL;
            end
            S_SERIAL: begin
               total_sr_ff <= {total_bit_in, total_sr_ff[TOTAL_W-1:1]};
               total_c_ff  <= total_c_in;
               if (low_bits) begin
                  made_sr_ff  <= {made_bit_in, made_sr_ff[DATA_W-1:1]};
                  made_c_ff   <= made_sr_ff[0] & made_c_ff;
                  eaten_sr_ff <= {eaten_bit_in, eaten_sr_ff[DATA_W-1:1]};
                  eaten_c_ff  <= eaten_sr_ff[0] & eaten_c_ff;
                  eaten_nz_ff <= eaten_nz_ff | eaten_sr_ff[0];
                  // higher differing bits override lower ones
                  if (d_sr_ff[0] != min_sr_ff[0]) begin
                     lt_ff <= min_sr_ff[0];
                  end
                  if (d_sr_ff[0] != max_sr_ff[0]) begin
                     gt_ff <= d_sr_ff[0];
                  end
                  min_sr_ff <= {min_sr_ff[0], min_sr_ff[DATA_W-1:1]};
                  max_sr_ff <= {max_sr_ff[0], max_sr_ff[DATA_W-1:1]};
                  d_sr_ff   <= {d_sr_ff[0], d_sr_ff[DATA_W-1:1]};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_CNT_W'(TOTAL_W - 1)) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               // carry out of a count or the total means it saturates
               if (made_c_ff) begin
                  made_sr_ff <= '1;
               end
               if (eaten_c_ff) begin
                  eaten_sr_ff <= '1;
               end
               if (total_c_ff) begin
                  total_sr_ff <= '1;
               end
               if (consumed) begin
                  if (first_sample || lt_ff) begin
                     min_sr_ff <= d_sr_ff;
                  end
                  if (first_sample || gt_ff) begin
                     max_sr_ff <= d_sr_ff;
                  end
               end
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               mismatch_ff <= (made_sr_ff != eaten_sr_ff);
               if (eaten_sr_ff != '0) begin
                  state_ff <= S_DIV;
               end else begin
                  avg_ff   <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  avg_ff   <= div_quot;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_data_ff  <= '{made_count: made_sr_ff, eaten_count: eaten_sr_ff,
                                    low_delay: min_sr_ff, peak_delay: max_sr_ff,
                                    mean_delay: avg_ff, mismatch: mismatch_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // Checks
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (eaten_sr_ff != '0))
      else $error("divider started with a zero eaten count");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.payload.eaten_count != '0))
         |-> (rsp_ch.payload.low_delay <= rsp_ch.payload.peak_delay))
      else $error("minimum delay above maximum delay");

endmodule

// ===== rtl/psls_divider.sv =====
module psls_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [psls_pkg::TOTAL_W-1:0]   dividend,
   input  logic [psls_pkg::DATA_W-1:0]    divisor,
   output logic                           done,
   output logic [psls_pkg::DATA_W-1:0]    quotient
);
   import psls_pkg::*;

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type           state_ff;
   logic [STEP_CNT_W-1:0]   cnt_ff;
   logic [DATA_W-1:0]       rem_ff;
   logic [TOTAL_W-1:0]      dq_ff;
   logic [DATA_W-1:0]       div_ff;
   logic                    done_ff;
   logic [DATA_W-1:0]       quot_ff;

   logic [DATA_W:0]         trial;
   logic [DATA_W+1:0]       diff;
   logic                    ge;
   logic [DATA_W-1:0]       rem_in;
   logic [TOTAL_W-1:0]      dq_in;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, dq_ff[TOTAL_W-1]};
      diff   = {1'b0, trial} - {2'b00, div_ff};
      ge     = ~diff[DATA_W+1];
      rem_in = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      dq_in  = {dq_ff[TOTAL_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == D_RUN) && (cnt_ff == STEP_CNT_W'(TOTAL_W - 1));
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff   <= '0;
                  dq_ff    <= dividend;
                  div_ff   <= divisor;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= rem_in;
               dq_ff  <= dq_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == STEP_CNT_W'(TOTAL_W - 1)) begin
                  // clamp a quotient that would not fit the result field
                  quot_ff  <= (|dq_in[TOTAL_W-1:DATA_W]) ? '1 : dq_in[DATA_W-1:0];
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== tb/tb_per_source_latency_stats_table_core.sv =====
`timescale 1ns / 100ps

module tb_per_source_latency_stats_table_core;
   import psls_pkg::*;

   localparam int NUM_SOURCES  = 16;
   localparam int STALL_LIMIT  = 2000;   // cycles with no request or result taken
   localparam int DRAIN_CYCLES = 150;    // a little over the slowest request

   localparam logic [CMD_W-1:0]   CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0]   CMD_SPARE = 2'd3;   // unused code, reads the entry
   localparam logic [DATA_W-1:0]  DATA_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   logic clock;
   logic reset;
   logic steady;          // no idling on either side while set
   int   fail_count;
   int   sent_count;
   int   checked_count;
   int   idle_cycles = 0;
   int   cmd_count [4];

   // Shadow copy of the statistics table
   logic [DATA_W-1:0]  made_tbl  [NUM_SOURCES];
   logic [DATA_W-1:0]  eaten_tbl [NUM_SOURCES];
   logic [DATA_W-1:0]  min_tbl   [NUM_SOURCES];
   logic [DATA_W-1:0]  max_tbl   [NUM_SOURCES];
   logic [TOTAL_W-1:0] total_tbl [NUM_SOURCES];

   rsp_payload_type pending_stats_q [$];

   psls_req_if req_ch ();
   psls_rsp_if rsp_ch ();

   per_source_latency_stats_table_core #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the shadow table and return the entry it leaves
   function automatic rsp_payload_type predict_entry_stats(req_payload_type item);
      rsp_payload_type    stats;
      logic [TOTAL_W:0]   sum;
      logic [TOTAL_W-1:0] quot;
      int                 idx;
      stats = '0;
      if (int'(item.source) >= NUM_SOURCES) return stats;
      idx = int'(item.source);
      if (item.cmd == CMD_PRODUCED) begin
         if (made_tbl[idx] != DATA_MAX) made_tbl[idx] = made_tbl[idx] + 1'b1;
      end else if (item.cmd == CMD_CONSUMED) begin
         // first sample sets both bounds; a saturated count is never first again
         if (eaten_tbl[idx] == '0) begin
            min_tbl[idx] = item.delay;
            max_tbl[idx] = item.delay;
         end else begin
            if (item.delay < min_tbl[idx]) min_tbl[idx] = item.delay;
            if (item.delay > max_tbl[idx]) max_tbl[idx] = item.delay;
         end
         if (eaten_tbl[idx] != DATA_MAX) eaten_tbl[idx] = eaten_tbl[idx] + 1'b1;
         sum = {1'b0, total_tbl[idx]} + item.delay;
         total_tbl[idx] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
      stats.made_count  = made_tbl[idx];
      stats.eaten_count = eaten_tbl[idx];
      stats.low_delay   = min_tbl[idx];
      stats.peak_delay  = max_tbl[idx];
      if (eaten_tbl[idx] != '0) begin
         quot = total_tbl[idx] / eaten_tbl[idx];
         stats.mean_delay = (quot > DATA_MAX) ? DATA_MAX : quot[DATA_W-1:0];
      end
      stats.mismatch = (made_tbl[idx] != eaten_tbl[idx]);
      return stats;
   endfunction

   // A mix of wide random samples, small values, single-bit values and edge values
   function automatic logic [DATA_W-1:0] pick_delay();
      case ($urandom_range(9))
         0:       return '0;
         1:       return DATA_MAX;
         2:       return DATA_W'(1) << $urandom_range(DATA_W-1);
         3, 4, 5: return DATA_W'($urandom_range(4095));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // Drive one request and hold it until taken; valid stays high into the next call
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] src,
                               logic [DATA_W-1:0] dly);
      req_payload_type item;
      item.cmd    = cmd;
      item.source = src;
      item.delay  = dly;
      while (!steady && $urandom_range(99) < 18) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_stats_q.push_back(predict_entry_stats(item));
      sent_count++;
      cmd_count[cmd]++;
   endtask

   task automatic compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   task automatic check_stats(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_stats_q.size() == 0) begin
         fail_count++;
         $display("%0t: result with no request pending, expected none, got %p", $time, got);
         return;
      end
      want = pending_stats_q.pop_front();
      checked_count++;
      compare_field("made_count",  want.made_count,  got.made_count);
      compare_field("eaten_count", want.eaten_count, got.eaten_count);
      compare_field("low_delay",   want.low_delay,   got.low_delay);
      compare_field("peak_delay",  want.peak_delay,  got.peak_delay);
      compare_field("mean_delay",  want.mean_delay,  got.mean_delay);
      compare_field("mismatch",    DATA_W'(want.mismatch), DATA_W'(got.mismatch));
   endtask

   // Result side: check every accepted result, stall at random unless steady is set
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_stats(rsp_ch.payload);
      rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
   end

   // Watchdog on progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or result accepted for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Never-touched entries read back as zero, through both read codes
   task automatic test_empty_entries();
      send_request(CMD_READ,  SRC_W'(0),  DATA_W'($urandom));
      send_request(CMD_SPARE, SRC_W'(15), DATA_MAX);
   endtask

   // First sample of zero must still count as first; later ones fold in
   task automatic test_first_sample();
      send_request(CMD_CONSUMED, SRC_W'(3), '0);
      send_request(CMD_CONSUMED, SRC_W'(3), DATA_W'(700));
      send_request(CMD_PRODUCED, SRC_W'(3), DATA_MAX);
      send_request(CMD_PRODUCED, SRC_W'(3), '0);
      send_request(CMD_CONSUMED, SRC_W'(9), DATA_W'(12345));
   endtask

   // Largest samples push the total past 32 bits; average of max samples is max
   task automatic test_extreme_delays();
      send_request(CMD_CONSUMED, SRC_W'(15), DATA_MAX);
      send_request(CMD_CONSUMED, SRC_W'(15), DATA_MAX);
      send_request(CMD_CONSUMED, SRC_W'(15), '0);
      send_request(CMD_SPARE,    SRC_W'(15), DATA_W'($urandom));
      send_request(CMD_CONSUMED, SRC_W'(0),  DATA_W'(1));
   endtask

   // Each command on one entry, plus an entry that only ever produces
   task automatic test_command_mix();
      send_request(CMD_PRODUCED, SRC_W'(7), DATA_W'($urandom));
      send_request(CMD_PRODUCED, SRC_W'(7), DATA_W'($urandom));
      send_request(CMD_PRODUCED, SRC_W'(7), DATA_W'($urandom));
      send_request(CMD_CONSUMED, SRC_W'(7), DATA_W'(3000));
      send_request(CMD_CONSUMED, SRC_W'(7), DATA_W'(1000));
      send_request(CMD_CONSUMED, SRC_W'(7), DATA_W'(2000));
      send_request(CMD_READ,     SRC_W'(7), DATA_MAX);
      send_request(CMD_PRODUCED, SRC_W'(8), '0);
      send_request(CMD_PRODUCED, SRC_W'(8), DATA_MAX);
   endtask

   // Mostly produce/consume pairs on one source, the rest any code at random
   task automatic run_random_traffic(int n_items);
      int               done;
      logic [SRC_W-1:0] src;
      done = 0;
      while (done < n_items) begin
         src = SRC_W'($urandom_range(NUM_SOURCES-1));
         if ($urandom_range(99) < 60) begin
            send_request(CMD_PRODUCED, src, DATA_W'($urandom));
            if ($urandom_range(3) == 0) begin
               send_request(CMD_READ, src, DATA_W'($urandom));
               done++;
            end
            send_request(CMD_CONSUMED, src, pick_delay());
            done += 2;
         end else begin
            send_request(CMD_W'($urandom_range(CMD_SPARE)), src, pick_delay());
            done++;
         end
      end
   endtask

   task automatic test_random_steady();
      steady = 1'b1;
      run_random_traffic(400);
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      run_random_traffic(1430);
   endtask

   initial begin
      steady        = 1'b0;
      fail_count    = 0;
      sent_count    = 0;
      checked_count = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      foreach (made_tbl[i]) begin
         made_tbl[i]  = '0;
         eaten_tbl[i] = '0;
         min_tbl[i]   = '0;
         max_tbl[i]   = '0;
         total_tbl[i] = '0;
      end
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_entries();
      test_first_sample();
      test_extreme_delays();
      test_command_mix();
      test_random_steady();
      test_random_traffic();
      req_ch.valid <= 1'b0;

      wait (pending_stats_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d produced, %0d consumed, %0d read, %0d spare code;",
               sent_count, cmd_count[CMD_PRODUCED], cmd_count[CMD_CONSUMED],
               cmd_count[CMD_READ], cmd_count[CMD_SPARE]);
      $display("%0d results checked field by field across all %0d sources.",
               checked_count, NUM_SOURCES);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
